@@ rtl/plic_pkg.sv @@
package plic_pkg;

   // Transfer kinds carried by an input item
   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_WRITE  = 2'd2;

   // Fixed field widths
   localparam int OFFSET_W = 26;
   localparam int DATA_W   = 32;
   localparam int LINES_W  = 32;

   // Register map, byte offsets
   localparam logic [OFFSET_W-1:0] OFF_PENDING   = 26'h000_1000;
   localparam logic [OFFSET_W-1:0] OFF_ENABLE    = 26'h000_2000;
   localparam logic [OFFSET_W-1:0] OFF_THRESHOLD = 26'h020_0000;
   localparam logic [OFFSET_W-1:0] OFF_CLAIM     = 26'h020_0004;

   // Register regions hit by an access
   typedef enum logic [2:0] {
      REG_NONE,
      REG_PRIORITY,
      REG_PENDING,
      REG_ENABLE,
      REG_THRESHOLD,
      REG_CLAIM
   } region_type;

   // One input item
   typedef struct packed {
      logic [1:0]          kind;
      logic [OFFSET_W-1:0] offset;
      logic [DATA_W-1:0]   write_data;
      logic [LINES_W-1:0]  source_lines;
   } req_type;

   // One result item
   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              external_irq;
      logic              bad_access;
   } rsp_type;

endpackage

@@ rtl/plic_arbiter.sv @@
module plic_arbiter #(
   parameter int SOURCES       = 32,
   parameter int PRIORITY_BITS = 3
) (
   input  logic [SOURCES-1:0]       cand,
   input  logic [PRIORITY_BITS-1:0] level [SOURCES],
   output logic                     found,
   output logic [$clog2(SOURCES)-1:0] best_id
);

   localparam int IDW    = $clog2(SOURCES);
   localparam int LEAVES = 1 << IDW;

   logic [LEAVES-1:0]        cand_pad;
   logic [PRIORITY_BITS-1:0] level_pad [LEAVES];
   logic                     node_v    [2*LEAVES];
   logic [PRIORITY_BITS-1:0] node_p    [2*LEAVES];
   logic [IDW-1:0]           node_id   [2*LEAVES];
   logic                     take_left;

   // Pad the candidates up to a power of two
   assign cand_pad = LEAVES'(cand);

   for (genvar g = 0; g < LEAVES; g++) begin : g_pad
      if (g < SOURCES) begin : g_real
         assign level_pad[g] = level[g];
      end else begin : g_empty
         assign level_pad[g] = '0;
      end
   end

   // Compare tree: higher priority wins, left (lower id) wins ties
   always_comb begin
      take_left = 1'b0;
      node_v[0]  = 1'b0;
      node_p[0]  = '0;
      node_id[0] = '0;
      for (int i = 0; i < LEAVES; i++) begin
         node_v[LEAVES+i]  = cand_pad[i];
         node_p[LEAVES+i]  = level_pad[i];
         node_id[LEAVES+i] = IDW'(i);
      end
      for (int n = LEAVES - 1; n >= 1; n--) begin
         take_left = node_v[2*n] && (!node_v[2*n+1] || node_p[2*n] >= node_p[2*n+1]);
         node_v[n]  = node_v[2*n] || node_v[2*n+1];
         node_p[n]  = take_left ? node_p[2*n]  : node_p[2*n+1];
         node_id[n] = take_left ? node_id[2*n] : node_id[2*n+1];
      end
   end

   assign found   = node_v[1];
   assign best_id = node_v[1] ? node_id[1] : '0;

endmodule

@@ rtl/plic_core.sv @@
module plic_core #(
   parameter int SOURCES       = 32,
   parameter int PRIORITY_BITS = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  plic_pkg::req_type item,
   output plic_pkg::rsp_type result
);

   localparam int IDW = $clog2(SOURCES);
   localparam logic [SOURCES-1:0] SRC_MASK = {{(SOURCES-1){1'b1}}, 1'b0};

   logic [PRIORITY_BITS-1:0] prio_ff [SOURCES];
   logic [PRIORITY_BITS-1:0] prio_in [SOURCES];
   logic [SOURCES-1:0]       enable_ff, enable_in;
   logic [PRIORITY_BITS-1:0] thr_ff, thr_in;
   logic [SOURCES-1:0]       pending_ff, pending_in;
   logic [SOURCES-1:0]       in_flight_ff, in_flight_in;

   logic [SOURCES-1:0]       lines;
   logic [SOURCES-1:0]       pend_gate;
   logic [SOURCES-1:0]       above;
   logic [SOURCES-1:0]       above_next;
   logic [SOURCES-1:0]       elig;
   logic                     claim_found;
   logic [IDW-1:0]           claim_id;
   logic [23:0]              word_addr;
   logic [IDW-1:0]           prio_idx;
   logic [IDW-1:0]           done_idx;
   logic                     done_ok;
   logic                     is_read;
   logic                     is_write;
   plic_pkg::region_type     region;
   logic [31:0]              rdata;
   logic                     bad;

   // Gateways: raise a line that is neither pending nor in flight
   assign lines     = item.source_lines[SOURCES-1:0] & SRC_MASK;
   assign pend_gate = pending_ff | (lines & ~in_flight_ff);

   // Eligible sources for a claim
   always_comb begin
      for (int i = 0; i < SOURCES; i++) begin
         above[i] = prio_ff[i] > thr_ff;
      end
   end

   assign elig = pend_gate & enable_ff & above;

   plic_arbiter #(
      .SOURCES       (SOURCES),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_arbiter (
      .cand    (elig),
      .level   (prio_ff),
      .found   (claim_found),
      .best_id (claim_id)
   );

   // Decode the access
   assign word_addr = item.offset[25:2];
   assign prio_idx  = item.offset[IDW+1:2];
   assign done_idx  = item.write_data[IDW-1:0];
   assign done_ok   = (item.write_data < 32'(SOURCES)) && (item.write_data != '0);
   assign is_read   = (item.kind == plic_pkg::KIND_READ);
   assign is_write  = (item.kind == plic_pkg::KIND_WRITE);

   always_comb begin
      if (item.offset[1:0] != 2'b00) begin
         region = plic_pkg::REG_NONE;
      end else if (word_addr < 24'(SOURCES)) begin
         region = plic_pkg::REG_PRIORITY;
      end else if (item.offset == plic_pkg::OFF_PENDING) begin
         region = plic_pkg::REG_PENDING;
      end else if (item.offset == plic_pkg::OFF_ENABLE) begin
         region = plic_pkg::REG_ENABLE;
      end else if (item.offset == plic_pkg::OFF_THRESHOLD) begin
         region = plic_pkg::REG_THRESHOLD;
      end else if (item.offset == plic_pkg::OFF_CLAIM) begin
         region = plic_pkg::REG_CLAIM;
      end else begin
         region = plic_pkg::REG_NONE;
      end
   end

   // Next state and read data
   always_comb begin
      prio_in      = prio_ff;
      enable_in    = enable_ff;
      thr_in       = thr_ff;
      pending_in   = pending_ff;
      in_flight_in = in_flight_ff;
      rdata        = '0;
      bad          = 1'b0;
      if (item_valid) begin
         pending_in = pend_gate;
         if (is_read || is_write) begin
            unique case (region)
               plic_pkg::REG_PRIORITY: begin
                  if (is_write) begin
                     if (prio_idx != '0) begin
                        prio_in[prio_idx] = item.write_data[PRIORITY_BITS-1:0];
                     end
                  end else begin
                     rdata = 32'(prio_ff[prio_idx]);
                  end
               end
               plic_pkg::REG_PENDING: begin
                  if (is_read) begin
                     rdata = 32'(pend_gate);
                  end
               end
               plic_pkg::REG_ENABLE: begin
                  if (is_write) begin
                     enable_in = item.write_data[SOURCES-1:0] & SRC_MASK;
                  end else begin
                     rdata = 32'(enable_ff);
                  end
               end
               plic_pkg::REG_THRESHOLD: begin
                  if (is_write) begin
                     thr_in = item.write_data[PRIORITY_BITS-1:0];
                  end else begin
                     rdata = 32'(thr_ff);
                  end
               end
               plic_pkg::REG_CLAIM: begin
                  if (is_write) begin
                     // complete: re-arm only a claimed, enabled source
                     if (done_ok) begin
                        if (in_flight_ff[done_idx] && enable_ff[done_idx]) begin
                           in_flight_in[done_idx] = 1'b0;
                        end
                     end
                  end else if (claim_found) begin
                     pending_in[claim_id]   = 1'b0;
                     in_flight_in[claim_id] = 1'b1;
                     rdata = 32'(claim_id);
                  end
               end
               default: begin
                  bad = 1'b1;
               end
            endcase
         end
      end
   end

   // Request line after the item
   always_comb begin
      for (int i = 0; i < SOURCES; i++) begin
         above_next[i] = prio_in[i] > thr_in;
      end
   end

   assign result.read_data    = rdata;
   assign result.external_irq = |(pending_in & enable_in & above_next);
   assign result.bad_access   = bad;

   // Hold controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SOURCES; i++) begin
            prio_ff[i] <= '0;
         end
         enable_ff    <= '0;
         thr_ff       <= '0;
         pending_ff   <= '0;
         in_flight_ff <= '0;
      end else begin
         prio_ff      <= prio_in;
         enable_ff    <= enable_in;
         thr_ff       <= thr_in;
         pending_ff   <= pending_in;
         in_flight_ff <= in_flight_in;
      end
   end

endmodule

@@ rtl/platform_interrupt_controller.sv @@
// Platform interrupt controller, one machine-mode context, standard map.
// Input channel: drive req_kind, req_offset, req_write_data and
// req_source_lines with start high; the transfer is taken at the rising
// edge where start is high and busy is low. busy never rises, so a new
// item may be given in every cycle. Every item samples the source lines
// and carries at most one bus read or write.
// Result channel: exactly one result per item. rsp_valid is high for one
// cycle with rsp_read_data, rsp_external_irq and rsp_bad_access; the
// receiver takes it at the edge that ends that cycle and cannot stall it.
// The result strobe is registered behind the taken item (input register,
// then result register), and the receiver accepts the result transfer at
// the edge that ends the strobe cycle. Throughput: one item per cycle.
// The claim search is a registered-to-registered priority compare tree
// over all sources, in the same cycle as the state update.
// Reset (synchronous, active high) clears priorities, enables, threshold,
// pending and in-flight bits and drops any item in progress.
module platform_interrupt_controller #(
   parameter int SOURCES       = 32,
   parameter int PRIORITY_BITS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [25:0] req_offset,
   input  logic [31:0] req_write_data,
   input  logic [31:0] req_source_lines,
   output logic        rsp_valid,
   output logic [31:0] rsp_read_data,
   output logic        rsp_external_irq,
   output logic        rsp_bad_access
);

   logic              valid_ff;
   plic_pkg::req_type req_ff;
   plic_pkg::req_type req_in;
   plic_pkg::rsp_type result;
   logic              rsp_valid_ff;
   plic_pkg::rsp_type rsp_ff;

   assign busy = 1'b0;

   assign req_in.kind         = req_kind;
   assign req_in.offset       = req_offset;
   assign req_in.write_data   = req_write_data;
   assign req_in.source_lines = req_source_lines;

   // Capture the incoming transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= start && !busy;
      end
      req_ff <= req_in;
   end

   plic_core #(
      .SOURCES       (SOURCES),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (valid_ff),
      .item       (req_ff),
      .result     (result)
   );

   // Register the result for one strobe cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff;
      end
      rsp_ff <= result;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_ff.read_data;
   assign rsp_external_irq = rsp_ff.external_irq;
   assign rsp_bad_access   = rsp_ff.bad_access;

`ifndef SYNTHESIS
   // every taken transfer yields a result through the input and result registers
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("result strobe missing after taken transfer");

   // no result without a transfer taken through the input and result registers
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result strobe without a transfer");

   // an unmapped access returns no data
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_access) |-> (rsp_read_data == 32'd0))
      else $error("bad access returned data");
`endif

endmodule
